/* hdl/pbd_pkg.sv */
// ----------------------------------------------------------------------------
// pbd_pkg
// Types and constants shared by the PackBits line decoder modules.
// ----------------------------------------------------------------------------
package pbd_pkg;

   // decoded bytes per result and the largest decoded line length counted
   localparam int LANE_BYTES   = 4;
   localparam int MAX_LINE_OUT = 65536;

   localparam int BYTE_W  = 8;
   localparam int LANE_W  = BYTE_W * LANE_BYTES;
   localparam int COUNT_W = $clog2(LANE_BYTES + 1);
   localparam int LEN_W   = $clog2(MAX_LINE_OUT + 1);
   localparam int LEFT_W  = 8;
   localparam int ERR_W   = 2;

   localparam logic [COUNT_W-1:0] LANE_COUNT = COUNT_W'(LANE_BYTES);
   localparam logic [LEFT_W-1:0]  LANE_STEP  = LEFT_W'(LANE_BYTES);
   localparam logic [LEN_W-1:0]   LINE_MAX   = LEN_W'(MAX_LINE_OUT);

   // header byte codes
   localparam logic [BYTE_W-1:0] HDR_NOP = 8'h80;

   // line error codes
   localparam logic [ERR_W-1:0] ERR_NONE    = 2'd0;
   localparam logic [ERR_W-1:0] ERR_LITERAL = 2'd1;
   localparam logic [ERR_W-1:0] ERR_RUN     = 2'd2;
   localparam logic [ERR_W-1:0] ERR_EMPTY   = 2'd3;

   // configuration register indexes and address decode
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [0:0] REG_RAW_MODE = 1'b0;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_LITERAL,
      PH_RUN
   } phase_type;

   typedef struct packed {
      logic [BYTE_W-1:0] code_byte;
      logic              line_end;
   } req_item_type;

   typedef struct packed {
      logic [LANE_W-1:0]  out_bytes;
      logic [COUNT_W-1:0] byte_count;
      logic               last;
      logic               line_done;
      logic [LEN_W-1:0]   line_length;
      logic [ERR_W-1:0]   error_code;
   } rsp_item_type;

   // one decoded item: a byte repeated byte_left times, plus line close info
   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic [LEFT_W-1:0] byte_left;
      logic              line_end;
      logic [LEN_W-1:0]  line_length;
      logic [ERR_W-1:0]  error_code;
   } desc_type;

endpackage

/* hdl/pbd_decode.sv */
// ----------------------------------------------------------------------------
// pbd_decode
// PackBits header tracking: turns each compressed byte into a descriptor of
// decoded bytes and keeps the per-line count and error status.
// ----------------------------------------------------------------------------
module pbd_decode (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  raw_mode,
   input  logic                  item_accept,
   input  pbd_pkg::req_item_type item,
   output pbd_pkg::desc_type     desc
);

   pbd_pkg::phase_type               phase_ff, phase_in;
   logic [pbd_pkg::LEFT_W-1:0]       literal_left_ff, literal_left_in;
   logic [pbd_pkg::LEFT_W-1:0]       run_length_ff, run_length_in;
   logic [pbd_pkg::LEN_W-1:0]        line_count_ff, line_count_in;

   logic [pbd_pkg::LEFT_W-1:0]       emit_n;
   logic [pbd_pkg::LEFT_W-1:0]       literal_dec;
   logic [pbd_pkg::LEN_W:0]          count_sum;
   logic [pbd_pkg::LEN_W-1:0]        count_new;
   logic [pbd_pkg::ERR_W-1:0]        err;
   logic                             is_literal_hdr;
   logic                             is_run_hdr;

   assign literal_dec    = literal_left_ff - 8'd1;
   assign is_literal_hdr = !item.code_byte[7];
   assign is_run_hdr     = item.code_byte[7] && (item.code_byte != pbd_pkg::HDR_NOP);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (item_accept && !raw_mode) begin
         unique case (phase_ff)
            pbd_pkg::PH_LITERAL: begin
               if (literal_dec == '0) phase_in = pbd_pkg::PH_HEADER;
            end
            pbd_pkg::PH_RUN: phase_in = pbd_pkg::PH_HEADER;
            pbd_pkg::PH_HEADER: begin
               if (is_literal_hdr) phase_in = pbd_pkg::PH_LITERAL;
               else if (is_run_hdr) phase_in = pbd_pkg::PH_RUN;
            end
            default: phase_in = pbd_pkg::PH_HEADER;
         endcase
      end
      if (item_accept && item.line_end) phase_in = pbd_pkg::PH_HEADER;
   end

   // byte counts, line status and the descriptor
   always_comb begin
      emit_n          = '0;
      err             = pbd_pkg::ERR_NONE;
      literal_left_in = literal_left_ff;
      run_length_in   = run_length_ff;
      if (raw_mode) begin
         emit_n = 8'd1;
      end else begin
         unique case (phase_ff)
            pbd_pkg::PH_LITERAL: begin
               emit_n          = 8'd1;
               literal_left_in = literal_dec;
               if (literal_dec != '0 && item.line_end) err = pbd_pkg::ERR_LITERAL;
            end
            pbd_pkg::PH_RUN: begin
               emit_n        = run_length_ff;
               run_length_in = '0;
            end
            pbd_pkg::PH_HEADER: begin
               if (is_literal_hdr) begin
                  literal_left_in = item.code_byte + 8'd1;
                  if (item.line_end) err = pbd_pkg::ERR_LITERAL;
               end else if (is_run_hdr) begin
                  // 1 - (h - 256)
                  run_length_in = pbd_pkg::LEFT_W'(9'd257 - {1'b0, item.code_byte});
                  if (item.line_end) err = pbd_pkg::ERR_RUN;
               end
            end
            default: emit_n = '0;
         endcase
      end

      count_sum = {1'b0, line_count_ff} + (pbd_pkg::LEN_W+1)'(emit_n);
      if (count_sum > {1'b0, pbd_pkg::LINE_MAX}) count_new = pbd_pkg::LINE_MAX;
      else count_new = count_sum[pbd_pkg::LEN_W-1:0];

      if (item.line_end && err == pbd_pkg::ERR_NONE && count_new == '0) begin
         err = pbd_pkg::ERR_EMPTY;
      end

      line_count_in = count_new;
      if (item.line_end) begin
         literal_left_in = '0;
         run_length_in   = '0;
         line_count_in   = '0;
      end

      desc.data_byte   = item.code_byte;
      desc.byte_left   = emit_n;
      desc.line_end    = item.line_end;
      desc.line_length = count_new;
      desc.error_code  = err;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= pbd_pkg::PH_HEADER;
         literal_left_ff <= '0;
         run_length_ff   <= '0;
         line_count_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         if (item_accept) begin
            literal_left_ff <= literal_left_in;
            run_length_ff   <= run_length_in;
            line_count_ff   <= line_count_in;
         end
      end
   end

   a_literal_left: assert property (@(posedge clock) disable iff (reset)
      phase_ff == pbd_pkg::PH_LITERAL |-> literal_left_ff != '0)
      else $error("literal phase with no bytes left");

   a_run_length: assert property (@(posedge clock) disable iff (reset)
      phase_ff == pbd_pkg::PH_RUN |-> (run_length_ff >= 8'd2 && run_length_ff <= 8'd128))
      else $error("run phase with bad run length");

   a_line_clear: assert property (@(posedge clock) disable iff (reset)
      item_accept && item.line_end |=> line_count_ff == '0 && phase_ff == pbd_pkg::PH_HEADER)
      else $error("line state not cleared at line end");

endmodule

/* hdl/pbd_expand.sv */
// ----------------------------------------------------------------------------
// pbd_expand
// Holds one descriptor and packs its bytes into lane-wide results, one
// result per cycle while rsp_ready does not stall, into the output register.
// ----------------------------------------------------------------------------
module pbd_expand (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  desc_load,
   input  pbd_pkg::desc_type     desc_in,
   output logic                  desc_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output pbd_pkg::rsp_item_type rsp_item
);

   pbd_pkg::desc_type     desc_ff;
   logic                  desc_valid_ff, desc_valid_in;
   pbd_pkg::rsp_item_type rsp_item_ff, rsp_item_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic                        skip;
   logic                        out_open;
   logic                        out_load;
   logic                        final_chunk;
   logic                        desc_free;
   logic [pbd_pkg::COUNT_W-1:0] chunk_count;

   // an item that decodes to nothing and does not close the line makes no result
   assign skip        = desc_valid_ff && desc_ff.byte_left == '0 && !desc_ff.line_end;
   assign out_open    = !rsp_valid_ff || rsp_ready;
   assign out_load    = desc_valid_ff && !skip && out_open;
   assign final_chunk = desc_ff.byte_left <= pbd_pkg::LANE_STEP;
   assign desc_free   = skip || (out_load && final_chunk);
   assign desc_ready  = !desc_valid_ff || desc_free;

   assign chunk_count = final_chunk ? desc_ff.byte_left[pbd_pkg::COUNT_W-1:0]
                                    : pbd_pkg::LANE_COUNT;

   always_comb begin
      for (int i = 0; i < pbd_pkg::LANE_BYTES; i++) begin
         if ((pbd_pkg::COUNT_W)'(i) < chunk_count) begin
            rsp_item_in.out_bytes[i*pbd_pkg::BYTE_W +: pbd_pkg::BYTE_W] = desc_ff.data_byte;
         end else begin
            rsp_item_in.out_bytes[i*pbd_pkg::BYTE_W +: pbd_pkg::BYTE_W] = '0;
         end
      end
      rsp_item_in.byte_count  = chunk_count;
      rsp_item_in.last        = final_chunk;
      rsp_item_in.line_done   = final_chunk && desc_ff.line_end;
      rsp_item_in.line_length = rsp_item_in.line_done ? desc_ff.line_length : '0;
      rsp_item_in.error_code  = rsp_item_in.line_done ? desc_ff.error_code
                                                      : pbd_pkg::ERR_NONE;
   end

   always_comb begin
      desc_valid_in = desc_valid_ff;
      if (desc_load) desc_valid_in = 1'b1;
      else if (desc_free) desc_valid_in = 1'b0;

      rsp_valid_in = rsp_valid_ff;
      if (out_load) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         desc_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         desc_valid_ff <= desc_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (desc_load) begin
         desc_ff <= desc_in;
      end else if (out_load && !final_chunk) begin
         desc_ff.byte_left <= desc_ff.byte_left - pbd_pkg::LANE_STEP;
      end
      if (out_load) rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_item_ff.line_done |-> rsp_item_ff.last)
      else $error("line closed on a result that is not last");

   a_full_lane: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_item_ff.last |-> rsp_item_ff.byte_count == pbd_pkg::LANE_COUNT)
      else $error("partial lane before the last result");

   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_item_ff.line_done
         |-> rsp_item_ff.line_length == '0 && rsp_item_ff.error_code == pbd_pkg::ERR_NONE)
      else $error("line status on a result that does not close the line");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      desc_load |-> desc_ready)
      else $error("descriptor loaded while busy");

endmodule

/* hdl/packbits_line_decoder.sv */
// ----------------------------------------------------------------------------
// packbits_line_decoder
// PackBits scan line decoder: one compressed byte per item in, up to four
// decoded bytes per result out, line length and error on the closing result.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  req_      in         req_valid/req_ready    req_item  (code_byte, line_end)
//  rsp_      out        rsp_valid/rsp_ready    rsp_item  (out_bytes .. error_code)
//  csr       in         psel/penable/pready    raw_mode at byte address 0
//
//  A run data byte of an n-byte run makes ceil(n/4) results, at most 32, as
//  the expander emits one result a cycle while rsp_ready does not stall it.
//  An accepted item is registered as a descriptor, then each result in the output register.
//  Reset clears the decode state, the line count and both valid flags.
//  A stalled rsp_ready holds the output register; the expander takes the next
//  item once the final result of its descriptor is loaded, which waits for a held result.
// ----------------------------------------------------------------------------
module packbits_line_decoder (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  pbd_pkg::req_item_type                 req_item,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output pbd_pkg::rsp_item_type                 rsp_item,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [pbd_pkg::CSR_ADDR_W-1:0]        paddr,
   input  logic [pbd_pkg::CSR_DATA_W-1:0]        pwdata,
   output logic [pbd_pkg::CSR_DATA_W-1:0]        prdata,
   output logic                                  pready
);

   logic              raw_mode_ff;
   logic              csr_write;
   logic              item_accept;
   logic              desc_ready;
   pbd_pkg::desc_type desc;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_mode_ff <= 1'b0;
      end else if (csr_write && paddr[pbd_pkg::CSR_ADDR_W-1:2] == pbd_pkg::REG_RAW_MODE) begin
         raw_mode_ff <= pwdata[0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[pbd_pkg::CSR_ADDR_W-1:2] == pbd_pkg::REG_RAW_MODE) prdata[0] = raw_mode_ff;
   end

   assign req_ready   = desc_ready;
   assign item_accept = req_valid && desc_ready;

   pbd_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .raw_mode    (raw_mode_ff),
      .item_accept (item_accept),
      .item        (req_item),
      .desc        (desc)
   );

   pbd_expand u_expand (
      .clock      (clock),
      .reset      (reset),
      .desc_load  (item_accept),
      .desc_in    (desc),
      .desc_ready (desc_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_item   (rsp_item)
   );

endmodule

/* sim/tb_packbits_line_decoder.sv */
// ----------------------------------------------------------------------------
// tb_packbits_line_decoder
// Self-checking bench for the PackBits line decoder. A directed table covers
// header extremes, line errors and mode changes. Random lines follow, mostly
// well formed with some noise and truncation. Every result is checked against
// the table value or a behavioral decoder kept in step with the accepted items.
// ----------------------------------------------------------------------------
module tb_packbits_line_decoder;

   localparam int MAX_RESULTS   = 32;
   localparam int DRAIN_CYCLES  = 40;
   localparam int HOLD_CYCLES   = 300;
   localparam int ITEM_TARGET   = 165;
   localparam int DIRECTED_ROWS = 25;

   localparam logic [pbd_pkg::CSR_ADDR_W-1:0] RAW_MODE_ADDR =
      (pbd_pkg::CSR_ADDR_W)'(4 * int'(pbd_pkg::REG_RAW_MODE));

   localparam pbd_pkg::rsp_item_type CLOSE_EMPTY = '{out_bytes: '0, byte_count: '0,
      last: 1'b1, line_done: 1'b1, line_length: '0, error_code: pbd_pkg::ERR_EMPTY};
   localparam pbd_pkg::rsp_item_type CLOSE_LITERAL = '{out_bytes: '0, byte_count: '0,
      last: 1'b1, line_done: 1'b1, line_length: '0, error_code: pbd_pkg::ERR_LITERAL};
   localparam pbd_pkg::rsp_item_type CLOSE_RUN = '{out_bytes: '0, byte_count: '0,
      last: 1'b1, line_done: 1'b1, line_length: '0, error_code: pbd_pkg::ERR_RUN};

   typedef struct {
      bit                    raw;
      logic [7:0]            code;
      bit                    line_end;
      bit                    typed;
      pbd_pkg::rsp_item_type want;
   } step_row_type;

   // raw, code byte, line end, typed result, typed result value
   step_row_type directed_rows [DIRECTED_ROWS] = '{
      '{1'b0, 8'h80, 1'b1, 1'b1, CLOSE_EMPTY},     // only a no-op header
      '{1'b0, 8'h00, 1'b1, 1'b1, CLOSE_LITERAL},   // literal header on line end
      '{1'b0, 8'h81, 1'b1, 1'b1, CLOSE_RUN},       // run header on line end
      '{1'b0, 8'hFF, 1'b0, 1'b0, '0},              // shortest run
      '{1'b0, 8'h5A, 1'b0, 1'b0, '0},
      '{1'b0, 8'h80, 1'b0, 1'b0, '0},              // skipped header mid-line
      '{1'b0, 8'h81, 1'b0, 1'b0, '0},              // longest run
      '{1'b0, 8'hFF, 1'b0, 1'b0, '0},
      '{1'b0, 8'h02, 1'b0, 1'b0, '0},
      '{1'b0, 8'h00, 1'b0, 1'b0, '0},
      '{1'b0, 8'h7F, 1'b0, 1'b0, '0},
      '{1'b0, 8'h80, 1'b1, 1'b0, '0},              // literal completes on line end
      '{1'b0, 8'h03, 1'b0, 1'b0, '0},
      '{1'b0, 8'h01, 1'b0, 1'b0, '0},
      '{1'b0, 8'h02, 1'b1, 1'b0, '0},              // literal cut short
      '{1'b0, 8'hFE, 1'b0, 1'b0, '0},
      '{1'b0, 8'h00, 1'b1, 1'b0, '0},              // run data closes the line
      '{1'b0, 8'h80, 1'b0, 1'b0, '0},
      '{1'b0, 8'h80, 1'b1, 1'b1, CLOSE_EMPTY},
      '{1'b0, 8'h7F, 1'b0, 1'b0, '0},              // longest literal, left open
      '{1'b0, 8'hAA, 1'b0, 1'b0, '0},
      '{1'b1, 8'h11, 1'b0, 1'b0, '0},              // raw mode mid-line
      '{1'b1, 8'hFF, 1'b0, 1'b0, '0},
      '{1'b1, 8'h00, 1'b1, 1'b0, '0},
      '{1'b0, 8'h01, 1'b1, 1'b1, CLOSE_LITERAL}    // decoding restarts at a header
   };

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   pbd_pkg::req_item_type          req_item = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   pbd_pkg::rsp_item_type          rsp_item;
   logic                           psel = 1'b0;
   logic                           penable = 1'b0;
   logic                           pwrite = 1'b0;
   logic [pbd_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [pbd_pkg::CSR_DATA_W-1:0] pwdata = '0;
   logic [pbd_pkg::CSR_DATA_W-1:0] prdata;
   logic                           pready;

   packbits_line_decoder u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   // decoder state mirrored from the accepted items
   bit                        raw_on = 1'b0;
   pbd_pkg::phase_type        dec_phase = pbd_pkg::PH_HEADER;
   int                        copy_left = 0;
   int                        run_left = 0;
   logic [pbd_pkg::LEN_W-1:0] line_bytes = '0;

   logic [pbd_pkg::LANE_W-1:0] acc_word;
   int                         acc_fill;
   pbd_pkg::rsp_item_type      step_words[$];
   pbd_pkg::rsp_item_type      results_due[$];

   bit         hold_rsp = 1'b0;
   int         fail_count = 0;
   int         items_sent = 0;
   int         results_seen = 0;
   int         lines_closed = 0;
   int         err_seen [4] = '{0, 0, 0, 0};
   logic [7:0] line_buf[$];

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("Mismatches found");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void flush_word();
      pbd_pkg::rsp_item_type w;
      if (acc_fill == 0)
         return;
      w = '0;
      w.out_bytes  = acc_word;
      w.byte_count = (pbd_pkg::COUNT_W)'(acc_fill);
      if (step_words.size() < MAX_RESULTS)
         step_words = {step_words, w};
      acc_word = '0;
      acc_fill = 0;
   endfunction

   function automatic void push_byte(logic [7:0] b);
      acc_word[8*acc_fill +: 8] = b;
      acc_fill++;
      if (line_bytes < pbd_pkg::LINE_MAX)
         line_bytes++;
      if (acc_fill >= pbd_pkg::LANE_BYTES)
         flush_word();
   endfunction

   // decodes one compressed byte into step_words and advances the state
   function automatic void decode_packbits_byte(pbd_pkg::req_item_type it);
      logic [pbd_pkg::ERR_W-1:0] err;
      pbd_pkg::rsp_item_type     w;
      err = pbd_pkg::ERR_NONE;
      step_words.delete();
      acc_word = '0;
      acc_fill = 0;
      if (raw_on) begin
         push_byte(it.code_byte);
      end else if (dec_phase == pbd_pkg::PH_LITERAL) begin
         push_byte(it.code_byte);
         copy_left--;
         if (copy_left == 0)
            dec_phase = pbd_pkg::PH_HEADER;
         else if (it.line_end)
            err = pbd_pkg::ERR_LITERAL;
      end else if (dec_phase == pbd_pkg::PH_RUN) begin
         for (int i = 0; i < run_left; i++)
            push_byte(it.code_byte);
         run_left  = 0;
         dec_phase = pbd_pkg::PH_HEADER;
      end else if (it.code_byte < pbd_pkg::HDR_NOP) begin
         copy_left = int'(it.code_byte) + 1;
         dec_phase = pbd_pkg::PH_LITERAL;
         if (it.line_end)
            err = pbd_pkg::ERR_LITERAL;
      end else if (it.code_byte != pbd_pkg::HDR_NOP) begin
         run_left  = 257 - int'(it.code_byte);
         dec_phase = pbd_pkg::PH_RUN;
         if (it.line_end)
            err = pbd_pkg::ERR_RUN;
      end
      flush_word();

      if (it.line_end) begin
         if (err == pbd_pkg::ERR_NONE && line_bytes == 0)
            err = pbd_pkg::ERR_EMPTY;
         if (step_words.size() == 0) begin
            w = '0;
            step_words = {step_words, w};
         end
         w = step_words.pop_back();
         w.line_done   = 1'b1;
         w.line_length = line_bytes;
         w.error_code  = err;
         step_words = {step_words, w};
         dec_phase  = pbd_pkg::PH_HEADER;
         copy_left  = 0;
         run_left   = 0;
         line_bytes = '0;
      end

      if (step_words.size() > 0) begin
         w = step_words.pop_back();
         w.last = 1'b1;
         step_words = {step_words, w};
      end
   endfunction

   task automatic send_item(input pbd_pkg::req_item_type it, input bit typed,
                            input pbd_pkg::rsp_item_type want);
      req_valid <= 1'b1;
      req_item  <= it;
      do
         @(posedge clock);
      while (!req_ready);
      decode_packbits_byte(it);
      if (typed)
         results_due = {results_due, want};
      else
         foreach (step_words[i])
            results_due = {results_due, step_words[i]};
      items_sent++;
   endtask

   task automatic idle_gap(input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_line(input bit no_gaps);
      pbd_pkg::req_item_type it;
      foreach (line_buf[i]) begin
         it.code_byte = line_buf[i];
         it.line_end  = (i == line_buf.size() - 1);
         if (!no_gaps)
            idle_gap(pick_gap());
         send_item(it, 1'b0, '0);
      end
   endtask

   // a no-op byte may still be in flight when the last result arrives
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (results_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_raw_mode(input bit v);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= RAW_MODE_ADDR;
      pwdata  <= (pbd_pkg::CSR_DATA_W)'(v);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      raw_on = v;
   endtask

   // appends one well-formed packet: skipped header, literal or run
   task automatic add_packet();
      int kind;
      int n;
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
         line_buf = {line_buf, pbd_pkg::HDR_NOP};
      end else if (kind < 5) begin
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 8);
         line_buf = {line_buf, 8'(n - 1)};
         repeat (n) line_buf = {line_buf, 8'($urandom)};
      end else begin
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 128) : $urandom_range(2, 16);
         line_buf = {line_buf, 8'(257 - n)};
         line_buf = {line_buf, 8'($urandom)};
      end
   endtask

   // receiver: random stalls, plus one long hold while the sender keeps going
   initial begin
      int gap;
      @(negedge reset);
      @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else begin
            gap = pick_gap();
            if (gap > 0) begin
               rsp_ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
   end

   always @(posedge clock) begin : check_results
      pbd_pkg::rsp_item_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (rsp_item.line_done) begin
            lines_closed++;
            err_seen[rsp_item.error_code]++;
         end
         if (results_due.size() == 0) begin
            $error("unexpected result item: out_bytes %h count %0d",
                   rsp_item.out_bytes, rsp_item.byte_count);
            fail_count++;
         end else begin
            want = results_due.pop_front();
            if (rsp_item.out_bytes !== want.out_bytes) begin
               $error("out_bytes: expected %h, got %h", want.out_bytes, rsp_item.out_bytes);
               fail_count++;
            end
            if (rsp_item.byte_count !== want.byte_count) begin
               $error("byte_count: expected %0d, got %0d", want.byte_count,
                      rsp_item.byte_count);
               fail_count++;
            end
            if (rsp_item.last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_item.last);
               fail_count++;
            end
            if (rsp_item.line_done !== want.line_done) begin
               $error("line_done: expected %0d, got %0d", want.line_done, rsp_item.line_done);
               fail_count++;
            end
            if (rsp_item.line_length !== want.line_length) begin
               $error("line_length: expected %0d, got %0d", want.line_length,
                      rsp_item.line_length);
               fail_count++;
            end
            if (rsp_item.error_code !== want.error_code) begin
               $error("error_code: expected %0d, got %0d", want.error_code,
                      rsp_item.error_code);
               fail_count++;
            end
         end
      end
   end

   initial begin
      pbd_pkg::req_item_type it;
      int                    line_no;
      int                    kind;
      bit                    no_gaps;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         if (directed_rows[r].raw != raw_on) begin
            wait_idle();
            write_raw_mode(directed_rows[r].raw);
         end
         it.code_byte = directed_rows[r].code;
         it.line_end  = directed_rows[r].line_end;
         idle_gap(pick_gap());
         send_item(it, directed_rows[r].typed, directed_rows[r].want);
      end

      line_no = 0;
      while (items_sent < ITEM_TARGET) begin
         if (line_no % 6 == 5 && $urandom_range(0, 1) == 0) begin
            wait_idle();
            write_raw_mode(!raw_on);
         end
         line_buf.delete();
         kind = $urandom_range(0, 99);
         if (raw_on || kind < 10) begin
            repeat ($urandom_range(1, 6)) line_buf = {line_buf, 8'($urandom)};
         end else begin
            repeat ($urandom_range(1, 4)) add_packet();
            // broken line: cut anywhere, usually mid-packet
            if (kind < 25)
               while (line_buf.size() > $urandom_range(1, line_buf.size()))
                  void'(line_buf.pop_back());
         end
         no_gaps = (line_no < 2) || ($urandom_range(0, 3) == 0);
         if (line_no == 0)
            hold_rsp = 1'b1;
         send_line(no_gaps);
         line_no++;
      end

      wait_idle();
      $display("Run: %0d items in, %0d results checked, %0d lines closed, both modes",
               items_sent, results_seen, lines_closed);
      $display("Line closes by code: ok %0d, literal %0d, run %0d, empty %0d",
               err_seen[pbd_pkg::ERR_NONE], err_seen[pbd_pkg::ERR_LITERAL],
               err_seen[pbd_pkg::ERR_RUN], err_seen[pbd_pkg::ERR_EMPTY]);
      if (fail_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
